@@ sv/dfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

   // frame store geometry
   localparam int unsigned STORE_DEPTH = 64;
   localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

   // fill count and result limit
   localparam int unsigned CNT_W       = 6;
   localparam int unsigned RESULT_CAP  = 62;
   localparam int unsigned LIMIT_CAP   =
      (RESULT_CAP < STORE_DEPTH - 1) ? RESULT_CAP : STORE_DEPTH - 1;

   localparam int unsigned BYTE_W      = 8;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN    = 2'd2;

   // register reset values
   localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd2;
   localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd3;
   localparam logic [CNT_W-1:0]  MAX_LEN_RST    = 6'd62;

   // frame store write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

   // frame release command from capture to readout
   typedef struct packed {
      logic             go;
      logic [CNT_W-1:0] count;
      logic             empty;
   } release_type;

   // readout sequencer states
   typedef enum logic {
      RD_IDLE,
      RD_SEND
   } rd_state_type;

endpackage : dfr_pkg
`default_nettype wire

@@ sv/dfr_frame_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_frame_ram
// Frame payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dfr_frame_ram (
   input  wire logic                         clock,
   input  wire dfr_pkg::ram_wr_type          wr,
   input  wire logic [dfr_pkg::ADDR_W-1:0]   rd_addr,
   output logic      [dfr_pkg::BYTE_W-1:0]   rd_data
);

   logic [dfr_pkg::BYTE_W-1:0] mem [dfr_pkg::STORE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : dfr_frame_ram
`default_nettype wire

@@ sv/dfr_capture.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_capture
// Frame delimiting: tracks in-frame state and fill count, writes payload
// bytes to the store and issues a release command on the end byte.
// ----------------------------------------------------------------------------
module dfr_capture (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         byte_valid,
   input  wire logic [dfr_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic [dfr_pkg::BYTE_W-1:0]   start_byte,
   input  wire logic [dfr_pkg::BYTE_W-1:0]   end_byte,
   input  wire logic [dfr_pkg::CNT_W-1:0]    length_limit,
   output dfr_pkg::ram_wr_type               wr,
   output dfr_pkg::release_type              rel
);

   logic                        in_frame_ff, in_frame_in;
   logic [dfr_pkg::CNT_W-1:0]   fill_ff, fill_in;

   logic [dfr_pkg::CNT_W-1:0]   base;
   logic [dfr_pkg::CNT_W:0]     fill_next;
   logic [dfr_pkg::CNT_W-1:0]   frame_len;

   // next state for each received byte
   always_comb begin
      in_frame_in = in_frame_ff;
      fill_in     = fill_ff;
      wr.en       = 1'b0;
      wr.addr     = dfr_pkg::ADDR_W'(fill_ff);
      wr.data     = rx_byte;
      rel.go      = 1'b0;
      rel.count   = '0;
      rel.empty   = 1'b0;

      // repeated start byte restarts the buffer
      base      = (rx_byte == start_byte) ? '0 : fill_ff;
      fill_next = {1'b0, base} + 1'b1;
      frame_len = (base > length_limit) ? length_limit : base;

      if (byte_valid) begin
         if (!in_frame_ff) begin
            if (rx_byte == start_byte) begin
               in_frame_in = 1'b1;
            end
         end else if (rx_byte != end_byte) begin
            // store payload byte, drop frame past the limit
            wr.en   = (32'(base) < dfr_pkg::STORE_DEPTH);
            wr.addr = dfr_pkg::ADDR_W'(base);
            if (fill_next > {1'b0, length_limit}) begin
               in_frame_in = 1'b0;
               fill_in     = '0;
            end else begin
               fill_in = fill_next[dfr_pkg::CNT_W-1:0];
            end
         end else begin
            // end byte releases the stored payload
            rel.go      = 1'b1;
            rel.count   = frame_len;
            rel.empty   = (frame_len == '0);
            in_frame_in = 1'b0;
            fill_in     = '0;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
      end
   end

endmodule : dfr_capture
`default_nettype wire

@@ sv/dfr_readout.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_readout
// Payload readout: walks the frame store from address zero and loads one
// result word per byte, or one flagged empty word, into the output register.
// ----------------------------------------------------------------------------
module dfr_readout (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dfr_pkg::release_type         rel,
   input  wire logic [dfr_pkg::BYTE_W-1:0]   rd_data,
   output logic      [dfr_pkg::ADDR_W-1:0]   rd_addr,
   output logic                              busy,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [dfr_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic      [0:0]                   rsp_tuser
);

   dfr_pkg::rd_state_type        state_ff, state_in;
   logic [dfr_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [dfr_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                         empty_ff, empty_in;
   logic                         data_ok_ff, data_ok_in;
   logic                         out_valid_ff, out_valid_in;
   logic [dfr_pkg::BYTE_W-1:0]   out_data_ff, out_data_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_empty_ff, out_empty_in;

   logic                         out_free;
   logic                         final_byte;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign final_byte = (dfr_pkg::CNT_W'(addr_ff) + 1'b1) == count_ff;

   // sequencer next state and output register load
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      empty_in     = empty_ff;
      data_ok_in   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;

      case (state_ff)
         dfr_pkg::RD_IDLE: begin
            if (rel.go) begin
               state_in = dfr_pkg::RD_SEND;
               addr_in  = '0;
               count_in = rel.count;
               empty_in = rel.empty;
            end
         end
         dfr_pkg::RD_SEND: begin
            data_ok_in = 1'b1;
            if (empty_ff) begin
               // empty frame: one flagged word
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_data_in  = '0;
                  out_last_in  = 1'b1;
                  out_empty_in = 1'b1;
                  state_in     = dfr_pkg::RD_IDLE;
               end
            end else if (data_ok_ff && out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = rd_data;
               out_last_in  = final_byte;
               out_empty_in = 1'b0;
               data_ok_in   = 1'b0;
               if (final_byte) begin
                  state_in = dfr_pkg::RD_IDLE;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = dfr_pkg::RD_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfr_pkg::RD_IDLE;
         data_ok_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_ok_ff   <= data_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      count_ff     <= count_in;
      empty_ff     <= empty_in;
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign rd_addr    = addr_ff;
   assign busy       = (state_ff != dfr_pkg::RD_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_empty_ff;

endmodule : dfr_readout
`default_nettype wire

@@ sv/delimited_frame_receiver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_frame_receiver
// Finds frames between a start byte and an end byte and streams the payload.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while no frame is being read out. Bytes
// are ignored until the start byte, then stored in a 64-entry frame RAM
// until the end byte; a repeated start byte restarts the frame and is kept
// as its first byte, and a frame longer than max_len (at most 62) is dropped
// silently. The end byte releases the payload as one word per byte with
// tlast on the final one, or one word flagged empty_frame for an empty
// frame. While a frame is read out req_tready stays low; each byte goes through
// the single RAM read port (address, then registered data) and can be held by
// any back-pressure on the result side. The final result word may still
// wait in the output register while new bytes are taken.
// ----------------------------------------------------------------------------
module delimited_frame_receiver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // received byte stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] rx_byte
   // payload stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [7:0]                      rsp_tdata,   // [7:0] payload_byte
   output logic                                 rsp_tlast,
   output logic      [0:0]                      rsp_tuser,   // [0] empty_frame
   // register write port
   input  wire logic                            csr_we,
   input  wire logic [dfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [7:0]                      csr_wdata
);

   logic [dfr_pkg::BYTE_W-1:0]   start_byte_ff;
   logic [dfr_pkg::BYTE_W-1:0]   end_byte_ff;
   logic [dfr_pkg::CNT_W-1:0]    max_len_ff;
   logic [dfr_pkg::CNT_W-1:0]    length_limit;

   logic                         byte_valid;
   logic                         busy;
   dfr_pkg::ram_wr_type          wr;
   dfr_pkg::release_type         rel;
   logic [dfr_pkg::ADDR_W-1:0]   rd_addr;
   logic [dfr_pkg::BYTE_W-1:0]   rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= dfr_pkg::START_BYTE_RST;
         end_byte_ff   <= dfr_pkg::END_BYTE_RST;
         max_len_ff    <= dfr_pkg::MAX_LEN_RST;
      end else if (csr_we) begin
         case (csr_index)
            dfr_pkg::CSR_START_BYTE: start_byte_ff <= csr_wdata;
            dfr_pkg::CSR_END_BYTE:   end_byte_ff   <= csr_wdata;
            dfr_pkg::CSR_MAX_LEN:    max_len_ff    <= csr_wdata[dfr_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // limit in force, saturated at the result cap
   assign length_limit = (32'(max_len_ff) > dfr_pkg::LIMIT_CAP)
                       ? dfr_pkg::CNT_W'(dfr_pkg::LIMIT_CAP) : max_len_ff;

   assign req_tready = !busy;
   assign byte_valid = req_tvalid && req_tready;

   dfr_capture u_capture (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (byte_valid),
      .rx_byte      (req_tdata),
      .start_byte   (start_byte_ff),
      .end_byte     (end_byte_ff),
      .length_limit (length_limit),
      .wr           (wr),
      .rel          (rel)
   );

   dfr_frame_ram u_frame_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dfr_readout u_readout (
      .clock      (clock),
      .reset      (reset),
      .rel        (rel),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // empty-frame word carries zero data and closes the frame
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("empty frame word malformed");

   // a released frame blocks input on the next cycle
   a_release_blocks: assert property (@(posedge clock) disable iff (reset)
      rel.go |=> !req_tready)
      else $error("input not held off during readout");

   // store is never written while a frame is read out
   a_no_write_in_readout: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !busy)
      else $error("frame store written during readout");

   // release only comes from an accepted byte
   a_release_on_accept: assert property (@(posedge clock) disable iff (reset)
      rel.go |-> byte_valid && (req_tdata == end_byte_ff))
      else $error("release without end byte");

endmodule : delimited_frame_receiver
`default_nettype wire

@@ tb/tb_delimited_frame_receiver.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimited_frame_receiver
// Self-checking bench for the delimited frame receiver.
// ----------------------------------------------------------------------------
// A short directed table covers idle bytes, the empty frame, the restart on a
// repeated start byte, a zero length limit, equal start and end bytes and the
// extreme delimiter values. Random phases follow, each with its own register
// setting, made mostly of well-formed frames with random payload plus
// truncated frames and line noise. Each payload word is checked against a
// typed row's word or a behavioral model of the frame buffer in the bench.
// ----------------------------------------------------------------------------
module tb_delimited_frame_receiver;

   // random words sent after the directed table
   localparam int RANDOM_ITEMS   = 240;
   // long enough for a 62 byte readout, worst receiver stall and sender gap
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles to let a frame in flight finish before touching the registers
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct packed {
      logic [7:0] payload;
      logic       last;
      logic       empty;
   } exp_word_type;

   typedef enum logic {
      ROW_BYTE,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [dfr_pkg::CSR_IDX_W-1:0] idx;
      logic [7:0]                    value;
      logic                          typed;
      exp_word_type                  word;
   } stim_row_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = 8'h00;   // [7:0] rx_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [7:0]                    rsp_tdata;            // [7:0] payload_byte
   logic                          rsp_tlast;
   logic [0:0]                    rsp_tuser;            // [0] empty_frame
   logic                          csr_we     = 1'b0;
   logic [dfr_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [7:0]                    csr_wdata  = 8'h00;

   // model state and register copies
   logic [7:0]           sof_byte;
   logic [7:0]           eof_byte;
   logic [5:0]           len_max;
   bit                   in_frame;
   int unsigned          fill_count;
   logic [7:0]           frame_buf [dfr_pkg::STORE_DEPTH];

   exp_word_type         released_words [$];
   exp_word_type         expected_words [$];
   stim_row_type         directed_rows  [$];

   int                   err_count    = 0;
   int                   active_items = 0;
   int                   burst_left   = 0;

   delimited_frame_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // frame buffer model: consumes one byte, leaves released words behind
   function automatic void frame_step(input logic [7:0] rx);
      int unsigned  limit;
      int unsigned  n;
      exp_word_type w;
      limit = (len_max > dfr_pkg::LIMIT_CAP) ? dfr_pkg::LIMIT_CAP : len_max;
      released_words.delete();
      if (!in_frame) begin
         if (rx == sof_byte)
            in_frame = 1'b1;
         return;
      end
      if (rx == sof_byte)
         fill_count = 0;
      if (rx != eof_byte) begin
         if (fill_count < dfr_pkg::STORE_DEPTH)
            frame_buf[fill_count] = rx;
         fill_count++;
      end else begin
         n = (fill_count > limit) ? limit : fill_count;
         if (n == 0) begin
            w.payload = 8'h00;
            w.last    = 1'b1;
            w.empty   = 1'b1;
            released_words.push_back(w);
         end else begin
            for (int k = 0; k < n; k++) begin
               w.payload = frame_buf[k];
               w.last    = (k + 1 == n);
               w.empty   = 1'b0;
               released_words.push_back(w);
            end
         end
         in_frame   = 1'b0;
         fill_count = 0;
      end
      // overlong frame is dropped silently
      if (fill_count > limit) begin
         in_frame   = 1'b0;
         fill_count = 0;
      end
   endfunction

   // send one word, wait for the handshake and book its results
   task automatic send_word(input logic [7:0] rx, input logic typed,
                            input exp_word_type tw);
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_step(rx);
      active_items++;
      if (typed)
         expected_words.push_back(tw);
      else
         foreach (released_words[i]) expected_words.push_back(released_words[i]);
      // bursty sender
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
      end
   endtask

   // stop sending and wait until the block has nothing left to deliver
   task automatic settle(input int extra);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic csr_write(input logic [dfr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         dfr_pkg::CSR_START_BYTE: sof_byte = value;
         dfr_pkg::CSR_END_BYTE:   eof_byte = value;
         dfr_pkg::CSR_MAX_LEN:    len_max  = value[5:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // table builders
   function automatic void add_byte(input logic [7:0] rx);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_BYTE;
      r.value = rx;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_typed(input logic [7:0] rx, input logic [7:0] pb,
                                     input logic lst, input logic emp);
      stim_row_type r;
      r              = '0;
      r.kind         = ROW_BYTE;
      r.value        = rx;
      r.typed        = 1'b1;
      r.word.payload = pb;
      r.word.last    = lst;
      r.word.empty   = emp;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_reg(input logic [dfr_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [7:0] value);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_REG;
      r.idx   = idx;
      r.value = value;
      directed_rows.push_back(r);
   endfunction

   // receiver back-pressure: free running, random, or stall bursts
   initial begin : rsp_pacing
      int mode;
      int hold;
      mode = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0)
            mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: begin
               if (hold > 0) begin
                  hold--;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 7) == 0)
                     hold = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   // payload word checker
   always @(posedge clock) begin : rsp_check
      exp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected word: data %02h last %b empty %b",
                        rsp_tdata, rsp_tlast, rsp_tuser[0]);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.payload || rsp_tlast !== want.last ||
                rsp_tuser[0] !== want.empty) begin
               err_count++;
               if (err_count <= 10)
                  $display("word mismatch: exp %02h/%b/%b got %02h/%b/%b",
                           want.payload, want.last, want.empty,
                           rsp_tdata, rsp_tlast, rsp_tuser[0]);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (!reset);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] s_val;
      logic [7:0] e_val;
      logic [5:0] m_val;
      logic [7:0] pb;
      int         phase_end;
      int         shape;
      int         len;

      // model reset state
      sof_byte   = dfr_pkg::START_BYTE_RST;
      eof_byte   = dfr_pkg::END_BYTE_RST;
      len_max    = dfr_pkg::MAX_LEN_RST;
      in_frame   = 1'b0;
      fill_count = 0;
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;

      // bytes ignored while idle
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(dfr_pkg::END_BYTE_RST);
      // empty frame
      add_byte(dfr_pkg::START_BYTE_RST);
      add_typed(dfr_pkg::END_BYTE_RST, 8'h00, 1'b1, 1'b1);
      // single zero byte
      add_byte(dfr_pkg::START_BYTE_RST);
      add_byte(8'h00);
      add_typed(dfr_pkg::END_BYTE_RST, 8'h00, 1'b1, 1'b0);
      // repeated start byte restarts the frame and is kept
      add_byte(dfr_pkg::START_BYTE_RST);
      add_byte(8'hFF);
      add_byte(8'h80);
      add_byte(dfr_pkg::START_BYTE_RST);
      add_byte(8'h55);
      add_byte(dfr_pkg::END_BYTE_RST);
      // zero length limit drops data, empty frame still reported
      add_reg(dfr_pkg::CSR_MAX_LEN, 8'd0);
      add_byte(dfr_pkg::START_BYTE_RST);
      add_byte(8'h41);
      add_byte(dfr_pkg::END_BYTE_RST);
      add_byte(dfr_pkg::START_BYTE_RST);
      add_typed(dfr_pkg::END_BYTE_RST, 8'h00, 1'b1, 1'b1);
      // start equals end: opens when idle, closes empty when buffering
      add_reg(dfr_pkg::CSR_START_BYTE, 8'hFF);
      add_reg(dfr_pkg::CSR_END_BYTE, 8'hFF);
      add_reg(dfr_pkg::CSR_MAX_LEN, 8'd62);
      add_byte(8'hFF);
      add_byte(8'h10);
      add_typed(8'hFF, 8'h00, 1'b1, 1'b1);
      // extreme delimiters with a one byte limit
      add_reg(dfr_pkg::CSR_START_BYTE, 8'h00);
      add_reg(dfr_pkg::CSR_MAX_LEN, 8'd1);
      add_byte(8'h00);
      add_byte(8'h7F);
      add_typed(8'hFF, 8'h7F, 1'b1, 1'b0);

      // reset
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            settle(SETTLE_CYCLES);
            csr_write(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_word(directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].word);
         end
      end

      // random phases, one register setting each
      active_items = 0;
      while (active_items < RANDOM_ITEMS) begin
         settle(SETTLE_CYCLES);
         case ($urandom_range(0, 3))
            0:       s_val = 8'h00;
            1:       s_val = 8'hFF;
            default: s_val = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 4))
            0:       e_val = s_val;
            1:       e_val = 8'h00;
            2:       e_val = 8'hFF;
            default: e_val = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 5))
            0:       m_val = 6'd0;
            1:       m_val = 6'd1;
            2:       m_val = 6'd62;
            3:       m_val = 6'($urandom_range(0, 62));
            default: m_val = 6'($urandom_range(2, 8));
         endcase
         csr_write(dfr_pkg::CSR_START_BYTE, s_val);
         csr_write(dfr_pkg::CSR_END_BYTE, e_val);
         csr_write(dfr_pkg::CSR_MAX_LEN, {2'b00, m_val});

         phase_end = active_items + $urandom_range(20, 50);
         while (active_items < phase_end && active_items < RANDOM_ITEMS) begin
            shape = $urandom_range(0, 9);
            if (shape < 8) begin
               // well-formed frame, mostly short, sometimes past the limit
               repeat ($urandom_range(0, 2))
                  send_word(8'($urandom_range(0, 255)), 1'b0, '0);
               send_word(sof_byte, 1'b0, '0);
               len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                                 : $urandom_range(0, 63);
               repeat (len) begin
                  do pb = 8'($urandom_range(0, 255)); while (pb == eof_byte);
                  send_word(pb, 1'b0, '0);
               end
               send_word(eof_byte, 1'b0, '0);
            end else if (shape == 8) begin
               // frame cut short, followed by whatever comes next
               send_word(sof_byte, 1'b0, '0);
               repeat ($urandom_range(1, 5))
                  send_word(8'($urandom_range(0, 255)), 1'b0, '0);
            end else begin
               // line noise
               repeat ($urandom_range(1, 4))
                  send_word(8'($urandom_range(0, 255)), 1'b0, '0);
            end
         end
      end

      // drain
      settle(DRAIN_CYCLES);
      if (expected_words.size() != 0) begin
         err_count += expected_words.size();
         $display("%0d expected words never arrived", expected_words.size());
      end
      if (err_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
